// ===== design/vrc4_pkg.sv =====
package vrc4_pkg;

    // Number of CHR bank registers and their width.
    localparam int ChrSlots    = 8;
    localparam int ChrIdxW     = $clog2(ChrSlots);
    localparam int BankW       = 12;

    // Address decode mask and the decoded register addresses.
    localparam logic [15:0] AddrMask      = 16'hF0CF;
    localparam logic [15:0] AddrPrgSel0   = 16'h8000;
    localparam logic [15:0] AddrPrgSel1   = 16'hA000;
    localparam logic [15:0] AddrMirror    = 16'h9000;
    localparam logic [15:0] AddrModeA     = 16'h9002;
    localparam logic [15:0] AddrModeB     = 16'h9080;
    localparam logic [15:0] AddrIrqLatLo  = 16'hF000;
    localparam logic [15:0] AddrIrqLatHi  = 16'hF001;
    localparam logic [15:0] AddrIrqCtrl   = 16'hF002;
    localparam logic [15:0] AddrIrqAck    = 16'hF003;

    // CHR register window: rows 0xB..0xE with address bits 11..2 clear.
    localparam logic [3:0]  ChrFirstRow   = 4'hB;
    localparam logic [3:0]  ChrLastRow    = 4'hE;
    localparam logic [15:0] ChrZeroMask   = 16'h0FFC;

    // Counter value at which a tick reloads and raises the interrupt.
    localparam logic [7:0]  IrqWrapValue  = 8'hFF;

    // Command codes on the input channel.
    typedef enum logic {
        CmdWrite = 1'b0,
        CmdTick  = 1'b1
    } command_t;

    // Result action codes.
    typedef enum logic [2:0] {
        ActNone   = 3'd0,
        ActPrg    = 3'd1,
        ActChr    = 3'd2,
        ActMirror = 3'd3,
        ActIrq    = 3'd4
    } action_t;

    // Mapper state carried between items.
    typedef struct packed {
        logic [ChrSlots-1:0][BankW-1:0] chr_bank;
        logic                           prg_swap;
        logic [7:0]                     irq_reload;
        logic [7:0]                     irq_count;
        logic [1:0]                     irq_ctrl;
    } map_state_t;

    // One result item.
    typedef struct packed {
        action_t          action;
        logic [2:0]       slot;
        logic [BankW-1:0] bank_number;
        logic             irq_request;
    } map_result_t;

endpackage

// ===== design/vrc4_decode.sv =====
module vrc4_decode
    import vrc4_pkg::*;
(
    input  command_t    command,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  map_state_t  state_cur,
    output map_state_t  state_new,
    output map_result_t result
);

    logic [15:0]        addr_m;
    logic [3:0]         addr_row;
    logic [3:0]         chr_row;
    logic               chr_hit;
    logic [ChrIdxW-1:0] chr_idx;
    logic [BankW-1:0]   chr_old;
    logic [BankW-1:0]   chr_new;

    // Masked address and CHR register window decode.
    assign addr_m   = address & AddrMask;
    assign addr_row = addr_m[15:12];
    assign chr_row  = addr_row - ChrFirstRow;
    assign chr_hit  = (addr_row >= ChrFirstRow) && (addr_row <= ChrLastRow)
                      && ((addr_m & ChrZeroMask) == 16'h0000);
    assign chr_idx  = {chr_row[1:0], addr_m[1]};
    assign chr_old  = state_cur.chr_bank[chr_idx];

    // Bit 0 of the address picks the low nibble or the upper eight bits.
    assign chr_new  = addr_m[0] ? {write_data, chr_old[3:0]}
                                : {chr_old[11:4], write_data[3:0]};

    // Item decode: one state update and one result per beat.
    always_comb begin
        state_new          = state_cur;
        result.action      = ActNone;
        result.slot        = 3'd0;
        result.bank_number = '0;
        result.irq_request = 1'b0;
        priority if (command == CmdTick) begin
            if (state_cur.irq_ctrl[1]) begin
                if (state_cur.irq_count == IrqWrapValue) begin
                    state_new.irq_count = state_cur.irq_reload;
                    result.action       = ActIrq;
                    result.irq_request  = 1'b1;
                end else begin
                    state_new.irq_count = state_cur.irq_count + 8'd1;
                end
            end
        end else if (chr_hit) begin
            state_new.chr_bank[chr_idx] = chr_new;
            result.action               = ActChr;
            result.slot                 = 3'(chr_idx);
            result.bank_number          = chr_new;
        end else begin
            unique case (addr_m)
                AddrPrgSel0: begin
                    result.action      = ActPrg;
                    result.slot        = state_cur.prg_swap ? 3'd2 : 3'd0;
                    result.bank_number = {4'b0000, write_data};
                end
                AddrPrgSel1: begin
                    result.action      = ActPrg;
                    result.slot        = 3'd1;
                    result.bank_number = {4'b0000, write_data};
                end
                AddrMirror: begin
                    result.action      = ActMirror;
                    result.bank_number = {10'b0, write_data[1:0]};
                end
                AddrModeA, AddrModeB: begin
                    state_new.prg_swap = write_data[1];
                end
                AddrIrqLatLo: begin
                    state_new.irq_reload = {state_cur.irq_reload[7:4], write_data[3:0]};
                end
                AddrIrqLatHi: begin
                    state_new.irq_reload = {write_data[3:0], state_cur.irq_reload[3:0]};
                end
                AddrIrqCtrl: begin
                    // Enabling the counter also reloads it from the latch.
                    state_new.irq_ctrl = write_data[1:0];
                    if (write_data[1]) begin
                        state_new.irq_count = state_cur.irq_reload;
                    end
                end
                AddrIrqAck: begin
                    state_new.irq_ctrl = state_cur.irq_ctrl[0] ? 2'b11 : 2'b00;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== design/vrc4_state.sv =====
module vrc4_state
    import vrc4_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       update,
    input  map_state_t state_next,
    output map_state_t state_q
);

    map_state_t state_reg;
    map_state_t reset_value;

    // Reset image: CHR register i holds bank i, everything else is zero.
    always_comb begin
        reset_value = '0;
        for (int i = 0; i < ChrSlots; i++) begin
            reset_value.chr_bank[i] = BankW'(i);
        end
    end

    // State advances once for every beat that leaves the input stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= reset_value;
        end else if (update) begin
            state_reg <= state_next;
        end
    end

    assign state_q = state_reg;

endmodule

// ===== design/vrc4_style_bank_and_irq_mapper_core.sv =====
// VRC4-style bank and IRQ mapper core.
//
// Input channel (s_): one beat is either a CPU register write (s_tuser = 0,
// address and data in s_tdata) or one scanline tick (s_tuser = 1).
// Result channel (m_): exactly one beat per input beat, in order, carrying
// the action code in m_tuser and slot, bank number and IRQ flag in m_tdata.
//
// Each beat passes an input register, then the write decode and state update,
// then the result register, which presents it on m_tdata and m_tuser. One beat
// is accepted every cycle while the result side takes beats; the mapper state
// is read combinationally and written when the beat moves to the result
// register, so a beat sees every change made by the beat before it.
//
// When the receiver stalls, the result register holds its beat and the input
// register can still take one more beat, after which s_tready drops.
// Reset empties both registers and returns the mapper state to its initial
// image: CHR register i holds bank i, swap mode, IRQ latch, counter and
// enable bits are zero.
module vrc4_style_bank_and_irq_mapper_core
    import vrc4_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // [15:0] address, [23:16] write_data
    input  logic [0:0]  s_tuser,  // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // [2:0] slot, [14:3] bank_number, [15] irq_request
    output logic [2:0]  m_tuser   // [2:0] action
);

    logic        in_valid_reg;
    command_t    in_cmd_reg;
    logic [15:0] in_addr_reg;
    logic [7:0]  in_data_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    map_result_t out_result_reg;
    logic        advance;
    map_state_t  state_q;
    map_state_t  state_next;
    map_result_t result;

    // Handshake: the input stage moves on when the result register is free.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= command_t'(s_tuser[0]);
            in_addr_reg <= s_tdata[15:0];
            in_data_reg <= s_tdata[23:16];
        end
    end

    // Decode and state update.
    vrc4_decode u_decode (
        .command    (in_cmd_reg),
        .address    (in_addr_reg),
        .write_data (in_data_reg),
        .state_cur  (state_q),
        .state_new  (state_next),
        .result     (result)
    );

    vrc4_state u_state (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .update     (advance),
        .state_next (state_next),
        .state_q    (state_q)
    );

    // Result register.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.action;
    assign m_tdata  = {out_result_reg.irq_request, out_result_reg.bank_number,
                       out_result_reg.slot};

    // The IRQ flag goes with the IRQ action and nothing else.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_result_reg.irq_request == (out_result_reg.action == ActIrq)))
        else $error("irq_request does not match the IRQ action");

    // A result without an action carries no slot and no bank.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_result_reg.action == ActNone)
        |-> (out_result_reg.slot == 3'd0 && out_result_reg.bank_number == '0))
        else $error("idle result carries a slot or bank");

    // With both stages full and the receiver stalled, no beat is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while pipeline is full");

    // An accepted beat always lands in the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted beat lost");

    // Reset leaves no result pending.
    assert property (@(posedge aclk) !aresetn |=> (!out_valid_reg && !in_valid_reg))
        else $error("pipeline not empty after reset");

endmodule
